/* design/rwr_pkg.sv */
// Shared types and constants of the reorder window receiver.
package rwr_pkg;

  localparam int SEQ_W = 16;
  localparam int PAY_W = 64;
  localparam int ACK_W = 17;
  localparam int CFG_W = 5;

  // Upper bound on messages released by one packet
  localparam logic [4:0] MAX_DRAIN = 5'd16;
  // Largest window the slot logic supports
  localparam logic [CFG_W-1:0] WIN_MAX = 5'd16;

  // Acknowledgement number before any delivery (-1)
  localparam logic signed [ACK_W-1:0] ACK_NONE = 17'h1FFFF;

  // Result kinds
  localparam logic KIND_MSG = 1'b0;
  localparam logic KIND_ACK = 1'b1;

  // Register indexes (address bit 2)
  localparam logic REG_SEQ_BITS = 1'b0;
  localparam logic REG_WINDOW   = 1'b1;

  // Effective configuration seen by front and back
  typedef struct packed {
    logic [SEQ_W-1:0] mask;
    logic [CFG_W-1:0] win;
  } cfg_t;

  // Classified packet waiting in the queue
  typedef struct packed {
    logic             ok;
    logic [SEQ_W-1:0] seq;
    logic [PAY_W-1:0] payload;
  } cmd_t;

  // Sequence mask for a given width, out-of-range widths taken as the maximum
  function automatic logic [SEQ_W-1:0] seq_mask(input logic [CFG_W-1:0] bits,
                                                 input logic [CFG_W-1:0] max_bits);
    logic [CFG_W-1:0] b;
    b = bits;
    if (bits == '0 || bits > max_bits) begin
      b = max_bits;
    end
    return 16'hFFFF >> (5'd16 - b);
  endfunction

endpackage

/* design/rwr_if.sv */
// Packet and result channel interfaces of the reorder window receiver.
interface rwr_in_if;
  logic                          valid;
  logic                          ready;
  logic [rwr_pkg::SEQ_W-1:0]     seq_number;
  logic                          checksum_ok;
  logic [rwr_pkg::PAY_W-1:0]     payload_word;

  modport source(output valid, seq_number, checksum_ok, payload_word, input ready);
  modport sink(input valid, seq_number, checksum_ok, payload_word, output ready);
endinterface

interface rwr_out_if;
  logic                             valid;
  logic                             ready;
  logic                             item_kind;
  logic [rwr_pkg::PAY_W-1:0]        message_word;
  logic signed [rwr_pkg::ACK_W-1:0] ack_number;
  logic                             last_item;

  modport source(output valid, item_kind, message_word, ack_number, last_item,
                 input ready);
  modport sink(input valid, item_kind, message_word, ack_number, last_item,
               output ready);
endinterface

/* design/rwr_front.sv */
// Front end: accepts packets, classifies them and queues them for the back end.
module rwr_front (
  input  logic            clk,
  input  logic            rst,
  input  rwr_pkg::cfg_t   cfg,
  rwr_in_if.sink          pkt,
  output rwr_pkg::cmd_t   cmd,
  output logic            cmd_valid,
  input  logic            cmd_ready
);

  rwr_pkg::cmd_t q [2];
  rwr_pkg::cmd_t entry;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          push;
  logic          pop;

  // Classify: good checksum and number inside the sequence space
  always_comb begin
    entry.ok      = pkt.checksum_ok &&
                    ((pkt.seq_number & ~cfg.mask) == '0);
    entry.seq     = pkt.seq_number;
    entry.payload = pkt.payload_word;
  end

  assign pkt.ready = (count != 2'd2);
  assign push      = pkt.valid && pkt.ready;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Hold queued packets
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

endmodule

/* design/rwr_back.sv */
// Back end: window test, slot buffer, in-order drain and acknowledgement.
module rwr_back #(
  parameter int BUFFER_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  rwr_pkg::cfg_t   cfg,
  input  rwr_pkg::cmd_t   cmd,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  rwr_out_if.source       res
);

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int IDX_X = IDX_W + 1;
  localparam logic [IDX_W:0]   DEPTH_EXT = IDX_X'(BUFFER_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(BUFFER_DEPTH - 1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_MSG, S_ACK} state_t;

  state_t                          state;
  logic [rwr_pkg::SEQ_W-1:0]       base;
  logic signed [rwr_pkg::ACK_W-1:0] last_acked;
  logic [IDX_W-1:0]                head;
  logic [BUFFER_DEPTH-1:0]         valid;
  logic [4:0]                      drained;
  logic [rwr_pkg::PAY_W-1:0]       rdata;
  logic [rwr_pkg::PAY_W-1:0]       mem [BUFFER_DEPTH];

  logic [rwr_pkg::SEQ_W-1:0]       off;
  logic                            in_win;
  logic [IDX_W:0]                  sum;
  logic [IDX_W-1:0]                phys;
  logic [IDX_W-1:0]                head_adv;
  logic                            store;
  logic                            rd_go;

  // Offset from the base and physical slot of the packet
  always_comb begin
    off    = (cmd.seq - base) & cfg.mask;
    in_win = cmd.ok && (off < {11'b0, cfg.win});
    sum    = {1'b0, head} + {1'b0, off[IDX_W-1:0]};
    phys   = (sum >= DEPTH_EXT) ? IDX_W'(sum - DEPTH_EXT) : sum[IDX_W-1:0];
  end

  assign head_adv  = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign cmd_ready = (state == S_IDLE);
  assign store     = (state == S_IDLE) && cmd_valid && in_win && !valid[phys];
  assign rd_go     = (state == S_READ) && (drained < rwr_pkg::MAX_DRAIN) && valid[head];

  // Sequence packets through store, drain and acknowledgement
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      base       <= '0;
      last_acked <= rwr_pkg::ACK_NONE;
      head       <= '0;
      valid      <= '0;
      drained    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (store) begin
              valid[phys] <= 1'b1;
            end
            drained <= '0;
            state   <= (in_win && off == '0) ? S_READ : S_ACK;
          end
        end
        S_READ: begin
          state <= rd_go ? S_MSG : S_ACK;
        end
        S_MSG: begin
          if (res.ready) begin
            valid[head] <= 1'b0;
            head        <= head_adv;
            last_acked  <= {1'b0, base};
            base        <= (base + 1'b1) & cfg.mask;
            drained     <= drained + 5'd1;
            state       <= S_READ;
          end
        end
        S_ACK: begin
          if (res.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Slot payload store: write on store, read the base slot for delivery
  always_ff @(posedge clk) begin
    if (store) begin
      mem[phys] <= cmd.payload;
    end
    if (rd_go) begin
      rdata <= mem[head];
    end
  end

  // Drive the result channel from the held state
  assign res.valid        = (state == S_MSG) || (state == S_ACK);
  assign res.item_kind    = (state == S_ACK) ? rwr_pkg::KIND_ACK : rwr_pkg::KIND_MSG;
  assign res.message_word = (state == S_MSG) ? rdata : '0;
  assign res.ack_number   = (state == S_ACK) ? last_acked : {1'b0, base};
  assign res.last_item    = (state == S_ACK);

endmodule

/* design/reorder_window_receiver.sv */
// Reorder window receiver: configuration registers, front end and back end.
// A packet off the window base goes from the queue head to S_ACK for its acknowledgement;
// a packet on the base goes to S_READ, which checks the base slot, then for each delivered
// message reads the slot and presents it in S_MSG, then acknowledges in S_ACK; stalls hold any step.
// A two-entry queue lets the input keep accepting while results wait.
// Synchronous reset clears slot valid flags, base and last ack.
module reorder_window_receiver #(
  parameter int BUFFER_DEPTH = 16,
  parameter int MAX_SEQ_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  rwr_in_if.sink      pkt,
  rwr_out_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [rwr_pkg::CFG_W-1:0] seq_bits;
  logic [rwr_pkg::CFG_W-1:0] window_size;
  rwr_pkg::cfg_t             cfg;
  rwr_pkg::cmd_t             cmd;
  logic                      cmd_valid;
  logic                      cmd_ready;
  logic [rwr_pkg::CFG_W-1:0] w;
  logic [rwr_pkg::SEQ_W:0]   space;

  assign pready = 1'b1;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_bits    <= 5'd16;
      window_size <= 5'd8;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        rwr_pkg::REG_SEQ_BITS: seq_bits    <= pwdata[4:0];
        rwr_pkg::REG_WINDOW:   window_size <= pwdata[4:0];
        default:               seq_bits    <= seq_bits;
      endcase
    end
  end

  assign prdata = {27'b0, (paddr[2] == rwr_pkg::REG_WINDOW) ? window_size : seq_bits};

  // Effective mask and window, saturated to buffer depth and sequence space
  always_comb begin
    cfg.mask = rwr_pkg::seq_mask(seq_bits, 5'(MAX_SEQ_BITS));
    space    = {1'b0, cfg.mask} + 17'd1;
    w        = window_size;
    if (w == '0) begin
      w = 5'd1;
    end
    if (w > rwr_pkg::WIN_MAX) begin
      w = rwr_pkg::WIN_MAX;
    end
    if (32'(w) > BUFFER_DEPTH) begin
      w = 5'(BUFFER_DEPTH);
    end
    if ({12'b0, w} > space) begin
      w = space[4:0];
    end
    cfg.win = w;
  end

  rwr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pkt       (pkt),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  rwr_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res       (res)
  );

endmodule

/* tb/reorder_window_receiver_tb.sv */
// Self-checking testbench of the reorder window receiver.
module reorder_window_receiver_tb;

  // One result as seen on the output channel
  typedef struct packed {
    logic                             kind;
    logic [rwr_pkg::PAY_W-1:0]        word;
    logic signed [rwr_pkg::ACK_W-1:0] number;
    logic                             last;
  } delivery_t;

  // Directed stimulus rows: a packet or a register write
  typedef enum logic [1:0] {ROW_PKT, ROW_SEQ_BITS, ROW_WINDOW} row_kind_t;

  typedef struct {
    row_kind_t                        kind;
    logic [rwr_pkg::SEQ_W-1:0]        seq;
    logic                             ok;
    logic [rwr_pkg::PAY_W-1:0]        word;
    bit                               typed;
    logic signed [rwr_pkg::ACK_W-1:0] ack;
    logic [rwr_pkg::CFG_W-1:0]        cfg;
  } row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rwr_in_if  pkt_if();
  rwr_out_if res_if();

  reorder_window_receiver u_dut (
    .clk     (clk),
    .rst     (rst),
    .pkt     (pkt_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state
  logic [rwr_pkg::CFG_W-1:0]        cfg_seq_bits;
  logic [rwr_pkg::CFG_W-1:0]        cfg_window;
  logic [rwr_pkg::SEQ_W-1:0]        window_base;
  logic signed [rwr_pkg::ACK_W-1:0] last_delivered;
  logic                             slot_full [16];
  logic [rwr_pkg::PAY_W-1:0]        slot_word [16];

  delivery_t pending_results[$];
  row_t      directed_rows[$];
  int        error_count;
  int        packets_sent;
  bit        send_gaps;
  bit        recv_stalls;
  int        stall_left;

  int phase_bits [7] = '{31, 3, 1, 16, 4, 17, 16};
  int phase_win  [7] = '{16, 5, 1, 31, 16, 0, 8};

  always #10 clk = ~clk;

  // Limit the run
  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  function automatic int unsigned seq_space();
    int unsigned b;
    b = cfg_seq_bits;
    if (b < 1 || b > 16) b = 16;
    return 32'd1 << b;
  endfunction

  function automatic int unsigned window_len(input int unsigned space);
    int unsigned w;
    w = cfg_window;
    if (w < 1) w = 1;
    if (w > 16) w = 16;
    if (w > space) w = space;
    return w;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    if ($urandom_range(0, 15) < 12) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic row_t pkt_row(input logic [rwr_pkg::SEQ_W-1:0] seq, input logic ok,
                                   input logic [rwr_pkg::PAY_W-1:0] word, input bit typed,
                                   input logic signed [rwr_pkg::ACK_W-1:0] ack);
    row_t r;
    r.kind  = ROW_PKT;
    r.seq   = seq;
    r.ok    = ok;
    r.word  = word;
    r.typed = typed;
    r.ack   = ack;
    r.cfg   = '0;
    return r;
  endfunction

  function automatic row_t cfg_row(input row_kind_t kind,
                                   input logic [rwr_pkg::CFG_W-1:0] val);
    row_t r;
    r       = pkt_row('0, 1'b0, '0, 1'b0, '0);
    r.kind  = kind;
    r.cfg   = val;
    return r;
  endfunction

  // Work out the results of one accepted packet and queue them.
  // A typed row supplies its own acknowledgement in place of the computed results.
  task automatic predict_delivery(input logic [rwr_pkg::SEQ_W-1:0] seq, input logic ok,
                                  input logic [rwr_pkg::PAY_W-1:0] word, input bit typed,
                                  input logic signed [rwr_pkg::ACK_W-1:0] typed_ack);
    int unsigned space;
    int unsigned win;
    int unsigned off;
    int          drained;
    delivery_t   r;
    space = seq_space();
    win   = window_len(space);
    if (ok && seq < space) begin
      off = (32'(seq) - 32'(window_base)) & (space - 1);
      if (off < win) begin
        // Keep the first copy of a duplicate
        if (!slot_full[off]) begin
          slot_full[off] = 1'b1;
          slot_word[off] = word;
        end
        // Release the run from the base, bounded per packet
        if (off == 0) begin
          drained = 0;
          while (drained < int'(rwr_pkg::MAX_DRAIN) && slot_full[0]) begin
            r.kind   = rwr_pkg::KIND_MSG;
            r.word   = slot_word[0];
            r.number = {1'b0, window_base};
            r.last   = 1'b0;
            if (!typed) pending_results.push_back(r);
            last_delivered = {1'b0, window_base};
            window_base    = 16'((32'(window_base) + 1) & (space - 1));
            for (int k = 0; k < 15; k++) begin
              slot_full[k] = slot_full[k+1];
              slot_word[k] = slot_word[k+1];
            end
            slot_full[15] = 1'b0;
            drained++;
          end
        end
      end
    end
    r.kind   = rwr_pkg::KIND_ACK;
    r.word   = '0;
    r.number = typed ? typed_ack : last_delivered;
    r.last   = 1'b1;
    pending_results.push_back(r);
  endtask

  // Offer one packet after an optional gap and hold it until transferred
  task automatic send_packet(input logic [rwr_pkg::SEQ_W-1:0] seq, input logic ok,
                             input logic [rwr_pkg::PAY_W-1:0] word, input bit typed,
                             input logic signed [rwr_pkg::ACK_W-1:0] typed_ack);
    int gap;
    gap = (send_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      pkt_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pkt_if.valid        <= 1'b1;
    pkt_if.seq_number   <= seq;
    pkt_if.checksum_ok  <= ok;
    pkt_if.payload_word <= word;
    do @(posedge clk); while (!pkt_if.ready);
    predict_delivery(seq, ok, word, typed, typed_ack);
    packets_sent++;
  endtask

  task automatic send_random(input logic [rwr_pkg::SEQ_W-1:0] seq, input logic ok);
    send_packet(seq, ok, {$urandom, $urandom}, 1'b0, '0);
  endtask

  // Drop the offer, hold until every expected result has come, then let the block settle
  task automatic wait_settled(input int tail);
    @(negedge clk);
    pkt_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Setup then access cycle; upper data bits are junk the register ignores
  task automatic write_register(input logic reg_index,
                                input logic [rwr_pkg::CFG_W-1:0] val);
    @(negedge clk);
    pkt_if.valid <= 1'b0;
    psel         <= 1'b1;
    penable      <= 1'b0;
    pwrite       <= 1'b1;
    paddr        <= {reg_index, 2'b00};
    pwdata       <= ($urandom & 32'hFFFF_FFE0) | 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_index == rwr_pkg::REG_SEQ_BITS) cfg_seq_bits = val;
    else cfg_window = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One run of in-window numbers in shuffled order, with noise and duplicates
  task automatic run_burst(input bit base_last);
    int unsigned space;
    int unsigned win;
    int unsigned n;
    int unsigned offs[$];
    int unsigned tmp;
    int          j;
    logic [rwr_pkg::SEQ_W-1:0] base0;
    logic [rwr_pkg::SEQ_W-1:0] seq;
    space = seq_space();
    win   = window_len(space);
    base0 = window_base;
    n     = base_last ? win : $urandom_range(1, win);
    for (int i = 0; i < n; i++) offs.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = offs[i];
      offs[i] = offs[j];
      offs[j] = tmp;
    end
    // Move the base number to the end to force the longest release
    if (base_last) begin
      foreach (offs[i]) if (offs[i] == 0) begin
        offs[i]   = offs[n-1];
        offs[n-1] = 0;
      end
    end
    foreach (offs[i]) begin
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1) == 0) send_random(16'($urandom), 1'($urandom));
        else send_random(16'($urandom_range(0, space - 1)), 1'($urandom));
      end
      seq = 16'((32'(base0) + offs[i]) & (space - 1));
      send_random(seq, (base_last || $urandom_range(0, 15) != 0));
      if ($urandom_range(0, 9) == 0) send_random(seq, 1'b1);
    end
  endtask

  // Result ready with random stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
      stall_left   = pick_gap() - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Compare each transfer with the oldest expectation
  always @(posedge clk) begin
    delivery_t got;
    delivery_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      got.kind   = res_if.item_kind;
      got.word   = res_if.message_word;
      got.number = res_if.ack_number;
      got.last   = res_if.last_item;
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: kind %0b word %h number %h last %0b",
                   got.kind, got.word, got.number, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: exp %0b %h %h %0b, got %0b %h %h %0b",
                     want.kind, want.word, want.number, want.last,
                     got.kind, got.word, got.number, got.last);
        end
      end
    end
  end

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    pkt_if.valid        = 1'b0;
    pkt_if.seq_number   = '0;
    pkt_if.checksum_ok  = 1'b0;
    pkt_if.payload_word = '0;
    res_if.ready        = 1'b0;
    stall_left          = 0;
    error_count         = 0;
    packets_sent        = 0;
    send_gaps           = 1'b1;
    recv_stalls         = 1'b1;
    cfg_seq_bits        = 5'd16;
    cfg_window          = 5'd8;
    window_base         = '0;
    last_delivered      = rwr_pkg::ACK_NONE;
    foreach (slot_full[i]) slot_full[i] = 1'b0;
    foreach (slot_word[i]) slot_word[i] = '0;

    // Directed rows: extremes, drops, duplicates, register corner values, wrap
    directed_rows.push_back(pkt_row(16'd0, 1'b0, '1, 1'b1, rwr_pkg::ACK_NONE));
    directed_rows.push_back(pkt_row(16'hFFFF, 1'b1, '0, 1'b1, rwr_pkg::ACK_NONE));
    directed_rows.push_back(pkt_row(16'd8, 1'b1, 64'h1234_5678_9ABC_DEF0, 1'b1,
                                    rwr_pkg::ACK_NONE));
    directed_rows.push_back(pkt_row(16'd7, 1'b1, 64'hA5A5_A5A5_5A5A_5A5A, 1'b1,
                                    rwr_pkg::ACK_NONE));
    directed_rows.push_back(pkt_row(16'd2, 1'b1, 64'h0000_0002_0000_0002, 1'b1,
                                    rwr_pkg::ACK_NONE));
    directed_rows.push_back(pkt_row(16'd2, 1'b1, 64'hDEAD_BEEF_DEAD_BEEF, 1'b1,
                                    rwr_pkg::ACK_NONE));
    directed_rows.push_back(pkt_row(16'd1, 1'b1, 64'h8000_0000_0000_0001, 1'b1,
                                    rwr_pkg::ACK_NONE));
    directed_rows.push_back(pkt_row(16'd0, 1'b1, '1, 1'b0, '0));
    directed_rows.push_back(pkt_row(16'd4, 1'b0, 64'h4444_4444_4444_4444, 1'b1, 17'sd2));
    directed_rows.push_back(pkt_row(16'd3, 1'b1, 64'h3333_3333_3333_3333, 1'b0, '0));
    directed_rows.push_back(cfg_row(ROW_SEQ_BITS, 5'd0));
    directed_rows.push_back(pkt_row(16'd5, 1'b1, 64'h5555_5555_5555_5555, 1'b1, 17'sd3));
    directed_rows.push_back(pkt_row(16'd4, 1'b1, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0, '0));
    directed_rows.push_back(cfg_row(ROW_WINDOW, 5'd0));
    directed_rows.push_back(pkt_row(16'd7, 1'b1, 64'h7777_7777_7777_7777, 1'b1, 17'sd5));
    directed_rows.push_back(pkt_row(16'd6, 1'b1, 64'h6666_6666_6666_6666, 1'b0, '0));
    directed_rows.push_back(cfg_row(ROW_SEQ_BITS, 5'd2));
    directed_rows.push_back(cfg_row(ROW_WINDOW, 5'd31));
    directed_rows.push_back(pkt_row(16'd8, 1'b1, 64'h8888_8888_8888_8888, 1'b1, 17'sd7));
    directed_rows.push_back(pkt_row(16'd1, 1'b1, 64'h1111_1111_1111_1111, 1'b1, 17'sd7));
    directed_rows.push_back(pkt_row(16'd0, 1'b1, 64'hFEDC_BA98_7654_3210, 1'b0, '0));
    directed_rows.push_back(pkt_row(16'd3, 1'b1, '0, 1'b1, 17'sd1));
    directed_rows.push_back(pkt_row(16'd2, 1'b1, 64'h2222_2222_2222_2222, 1'b0, '0));
    directed_rows.push_back(cfg_row(ROW_SEQ_BITS, 5'd1));
    directed_rows.push_back(cfg_row(ROW_WINDOW, 5'd16));
    directed_rows.push_back(pkt_row(16'd1, 1'b1, 64'hC3C3_C3C3_C3C3_C3C3, 1'b1, 17'sd3));
    directed_rows.push_back(pkt_row(16'd0, 1'b1, 64'h3C3C_3C3C_3C3C_3C3C, 1'b0, '0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_PKT: begin
          send_packet(directed_rows[i].seq, directed_rows[i].ok, directed_rows[i].word,
                      directed_rows[i].typed, directed_rows[i].ack);
        end
        ROW_SEQ_BITS: begin
          wait_settled(8);
          write_register(rwr_pkg::REG_SEQ_BITS, directed_rows[i].cfg);
        end
        default: begin
          wait_settled(8);
          write_register(rwr_pkg::REG_WINDOW, directed_rows[i].cfg);
        end
      endcase
    end

    // Random phases, each under its own setting and idling mix
    for (int p = 0; p < 7; p++) begin
      wait_settled(8);
      write_register(rwr_pkg::REG_SEQ_BITS, 5'(phase_bits[p]));
      write_register(rwr_pkg::REG_WINDOW, 5'(phase_win[p]));
      send_gaps   = (p % 3 != 2);
      recv_stalls = (p % 4 != 2);
      packets_sent = 0;
      run_burst(p == 0);
      while (packets_sent < 10) run_burst(1'b0);
    end

    // Drain and finish
    @(negedge clk);
    pkt_if.valid <= 1'b0;
    wait_settled(40);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
